>>> design/dcpid_pkg.sv
package dcpid_pkg;

  localparam int CHANNELS = 2;
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int GAIN_W  = 24;
  localparam int LIMIT_W = 23;
  localparam int DEAD_W  = 15;
  localparam int COUNT_W = 16;
  localparam int INTEG_W = 24;
  localparam int DERIV_W = COUNT_W + 1;
  localparam int DRIVE_W = 48;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam int PROD_P_W = GAIN_W + COUNT_W;
  localparam int PROD_I_W = GAIN_W + INTEG_W;
  localparam int PROD_D_W = GAIN_W + DERIV_W;
  localparam int SUM_W    = DRIVE_W + 8;

  localparam logic signed [GAIN_W-1:0]  GAIN_P_RESET = 24'sd1311;
  localparam logic signed [GAIN_W-1:0]  GAIN_I_RESET = 24'sd1966;
  localparam logic signed [GAIN_W-1:0]  GAIN_D_RESET = 24'sd0;
  localparam logic [LIMIT_W-1:0]        LIMIT_RESET  = 23'd512;
  localparam logic [DEAD_W-1:0]         DEAD_RESET   = 15'd0;
  localparam logic signed [COUNT_W-1:0] TARGET_RESET = 16'sd0;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_DEAD_BAND      = 3'd4,
    REG_TARGET_A       = 3'd5,
    REG_TARGET_B       = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0]  gain_p;
    logic signed [GAIN_W-1:0]  gain_i;
    logic signed [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0]        integral_limit;
    logic [DEAD_W-1:0]         dead_band;
    logic signed [COUNT_W-1:0] target_a;
    logic signed [COUNT_W-1:0] target_b;
  } cfg_t;

  typedef struct packed {
    logic signed [INTEG_W-1:0] integ;
    logic signed [COUNT_W-1:0] prev_err;
  } state_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    state_t           data;
  } ram_wr_t;

  typedef struct packed {
    logic                      ch;
    logic signed [COUNT_W-1:0] err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DERIV_W-1:0] deriv;
  } upd_t;

endpackage

>>> design/dcpid_cfg.sv
module dcpid_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [dcpid_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [dcpid_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output dcpid_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p         <= dcpid_pkg::GAIN_P_RESET;
      cfg.gain_i         <= dcpid_pkg::GAIN_I_RESET;
      cfg.gain_d         <= dcpid_pkg::GAIN_D_RESET;
      cfg.integral_limit <= dcpid_pkg::LIMIT_RESET;
      cfg.dead_band      <= dcpid_pkg::DEAD_RESET;
      cfg.target_a       <= dcpid_pkg::TARGET_RESET;
      cfg.target_b       <= dcpid_pkg::TARGET_RESET;
    end else if (cfg_wr_en) begin
      case (dcpid_pkg::reg_idx_t'(cfg_addr))
        dcpid_pkg::REG_GAIN_P:         cfg.gain_p <= cfg_wdata;
        dcpid_pkg::REG_GAIN_I:         cfg.gain_i <= cfg_wdata;
        dcpid_pkg::REG_GAIN_D:         cfg.gain_d <= cfg_wdata;
        dcpid_pkg::REG_INTEGRAL_LIMIT: cfg.integral_limit <= cfg_wdata[dcpid_pkg::LIMIT_W-1:0];
        dcpid_pkg::REG_DEAD_BAND:      cfg.dead_band <= cfg_wdata[dcpid_pkg::DEAD_W-1:0];
        dcpid_pkg::REG_TARGET_A:       cfg.target_a <= cfg_wdata[dcpid_pkg::COUNT_W-1:0];
        dcpid_pkg::REG_TARGET_B:       cfg.target_b <= cfg_wdata[dcpid_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/dcpid_state_ram.sv
module dcpid_state_ram (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [dcpid_pkg::IDX_W-1:0]   rd_idx,
  output dcpid_pkg::state_t             rd_data,
  input  dcpid_pkg::ram_wr_t            wr
);

  dcpid_pkg::state_t               mem [dcpid_pkg::CHANNELS];
  logic [dcpid_pkg::CHANNELS-1:0]  written;
  dcpid_pkg::state_t               rd_q;
  logic                            rd_hit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_hit  <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= written[rd_idx];
      end
    end
  end

  // never-written entries read as the cleared state
  assign rd_data = rd_hit ? rd_q : '0;

endmodule

>>> design/dcpid_update.sv
module dcpid_update (
  input  logic                                clk,
  input  logic                                rst,
  input  dcpid_pkg::cfg_t                     cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_ch,
  input  logic signed [dcpid_pkg::COUNT_W-1:0] in_count,
  output logic                                rd_en,
  output logic [dcpid_pkg::IDX_W-1:0]         rd_idx,
  input  dcpid_pkg::state_t                   rd_data,
  output dcpid_pkg::ram_wr_t                  wr,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dcpid_pkg::upd_t                     out_data
);

  localparam int IW = dcpid_pkg::INTEG_W + 1;
  localparam int EW = dcpid_pkg::COUNT_W + 1;

  logic                                 v1;
  logic                                 v2;
  logic                                 rdy1;
  logic                                 rdy2;
  logic                                 acc;
  logic                                 adv1;

  logic signed [dcpid_pkg::COUNT_W-1:0] target;
  logic signed [dcpid_pkg::COUNT_W-1:0] err_raw;
  logic signed [EW-1:0]                 err_ext;
  logic signed [EW-1:0]                 dead_ext;
  logic signed [dcpid_pkg::COUNT_W-1:0] err0;
  logic [dcpid_pkg::IDX_W-1:0]          idx0;

  logic                                 s1_ch;
  logic [dcpid_pkg::IDX_W-1:0]          s1_idx;
  logic signed [dcpid_pkg::COUNT_W-1:0] s1_err;

  logic                                 fwd_valid;
  logic [dcpid_pkg::IDX_W-1:0]          fwd_idx;
  dcpid_pkg::state_t                    fwd_state;

  dcpid_pkg::state_t                    cur;
  logic signed [IW-1:0]                 sum;
  logic signed [IW-1:0]                 lim;
  logic signed [IW-1:0]                 clamped;
  logic signed [dcpid_pkg::INTEG_W-1:0] integ;
  logic signed [dcpid_pkg::DERIV_W-1:0] deriv;

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign acc      = in_valid && rdy1;
  assign adv1     = v1 && rdy2;

  always_comb begin
    target   = in_ch ? cfg.target_b : cfg.target_a;
    err_raw  = target - in_count;
    err_ext  = EW'(err_raw);
    dead_ext = $signed({2'b00, cfg.dead_band});
    if ((err_ext > -dead_ext) && (err_ext < dead_ext)) begin
      err0 = '0;
    end else begin
      err0 = err_raw;
    end
    if (int'(in_ch) < dcpid_pkg::CHANNELS) begin
      idx0 = dcpid_pkg::IDX_W'(in_ch);
    end else begin
      idx0 = dcpid_pkg::IDX_W'(dcpid_pkg::CHANNELS - 1);
    end
  end

  assign rd_en  = acc;
  assign rd_idx = idx0;

  always_comb begin
    if (fwd_valid && (fwd_idx == s1_idx)) begin
      cur = fwd_state;
    end else begin
      cur = rd_data;
    end
    sum = IW'(cur.integ) + IW'($signed({s1_err, 8'b0}));
    lim = $signed({2'b00, cfg.integral_limit});
    if (sum > lim) begin
      clamped = lim;
    end else if (sum < -lim) begin
      clamped = -lim;
    end else begin
      clamped = sum;
    end
    integ = clamped[dcpid_pkg::INTEG_W-1:0];
    deriv = dcpid_pkg::DERIV_W'(s1_err) - dcpid_pkg::DERIV_W'(cur.prev_err);
  end

  assign wr.en            = adv1;
  assign wr.idx           = s1_idx;
  assign wr.data.integ    = integ;
  assign wr.data.prev_err = s1_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (acc) begin
        v1 <= 1'b1;
      end else if (adv1) begin
        v1 <= 1'b0;
      end
      if (adv1) begin
        v2        <= 1'b1;
        fwd_valid <= 1'b1;
      end else if (out_ready) begin
        v2 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ch  <= in_ch;
      s1_idx <= idx0;
      s1_err <= err0;
    end
    if (adv1) begin
      fwd_idx        <= s1_idx;
      fwd_state      <= wr.data;
      out_data.ch    <= s1_ch;
      out_data.err   <= s1_err;
      out_data.integ <= integ;
      out_data.deriv <= deriv;
    end
  end

  assign out_valid = v2;

endmodule

>>> design/dcpid_drive.sv
module dcpid_drive (
  input  logic                                clk,
  input  logic                                rst,
  input  dcpid_pkg::cfg_t                     cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dcpid_pkg::upd_t                     in_data,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic                                m_tuser,
  output logic [dcpid_pkg::DRIVE_W-1:0]       m_tdata
);

  localparam int SW = dcpid_pkg::SUM_W;

  logic                                  v3;
  logic                                  rdy3;
  logic                                  rdyo;
  logic                                  ch3;
  logic signed [dcpid_pkg::PROD_P_W-1:0] prod_p;
  logic signed [dcpid_pkg::PROD_I_W-1:0] prod_i;
  logic signed [dcpid_pkg::PROD_D_W-1:0] prod_d;
  logic signed [dcpid_pkg::PROD_P_W-1:0] prod_p_next;
  logic signed [dcpid_pkg::PROD_I_W-1:0] prod_i_next;
  logic signed [dcpid_pkg::PROD_D_W-1:0] prod_d_next;
  logic signed [SW-1:0]                  sum;

  assign rdyo     = !m_tvalid || m_tready;
  assign rdy3     = !v3 || rdyo;
  assign in_ready = rdy3;

  always_comb begin
    prod_p_next = cfg.gain_p * in_data.err;
    prod_i_next = cfg.gain_i * in_data.integ;
    prod_d_next = cfg.gain_d * in_data.deriv;
  end

  // Q.24 sum, floor to Q.16 by dropping the low 8 bits
  assign sum = (SW'(prod_p) <<< 8) + SW'(prod_i) + (SW'(prod_d) <<< 8);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (in_valid && rdy3) begin
        v3 <= 1'b1;
      end else if (rdyo) begin
        v3 <= 1'b0;
      end
      if (v3 && rdyo) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy3) begin
      ch3    <= in_data.ch;
      prod_p <= prod_p_next;
      prod_i <= prod_i_next;
      prod_d <= prod_d_next;
    end
    if (v3 && rdyo) begin
      m_tuser <= ch3;
      m_tdata <= sum[SW-1:8];
    end
  end

endmodule

>>> design/dual_channel_pid_deadzone.sv
// Two-channel PID position loop with deadzone and integral clamp.
// Input stream (s_*): one item per encoder sample, channel in s_tuser and
// the signed count in s_tdata. Output stream (m_*): one item per input, in
// input order, channel in m_tuser and the signed Q32.16 drive in m_tdata.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_addr (0 gain_p,
// 1 gain_i, 2 gain_d, 3 integral_limit, 4 dead_band, 5 target_a, 6 target_b);
// other indexes are ignored. Write only while no item is in flight.
// Throughput: one item per cycle while m_tready is high. Four register
// stages: error and state read, integral update and write-back, the three
// gain multiplies, and the sum into the output register.
// Integral and previous error live in a per-channel state memory with a
// registered read; a back-to-back item on the same channel takes the value
// just written from a forwarding register.
// Reset: registers return to their defaults, the pipeline empties and the
// state reads as zero until each channel is written again.
// Stall: when m_tready is low the output holds; earlier stages keep filling
// until the pipeline is full, then s_tready drops.
module dual_channel_pid_deadzone (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic                              s_tuser,  // [0] channel
  input  logic [dcpid_pkg::COUNT_W-1:0]     s_tdata,  // [15:0] position
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic                              m_tuser,  // [0] channel_out
  output logic [dcpid_pkg::DRIVE_W-1:0]     m_tdata,  // [47:0] drive
  input  logic                              cfg_wr_en,
  input  logic [dcpid_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [dcpid_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  dcpid_pkg::cfg_t                   cfg;
  logic                              rd_en;
  logic [dcpid_pkg::IDX_W-1:0]       rd_idx;
  dcpid_pkg::state_t                 rd_data;
  dcpid_pkg::ram_wr_t                wr;
  logic                              upd_valid;
  logic                              upd_ready;
  dcpid_pkg::upd_t                   upd_data;

  dcpid_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dcpid_state_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .wr      (wr)
  );

  dcpid_update u_update (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_ch     (s_tuser),
    .in_count  ($signed(s_tdata)),
    .rd_en     (rd_en),
    .rd_idx    (rd_idx),
    .rd_data   (rd_data),
    .wr        (wr),
    .out_valid (upd_valid),
    .out_ready (upd_ready),
    .out_data  (upd_data)
  );

  dcpid_drive u_drive (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (upd_valid),
    .in_ready (upd_ready),
    .in_data  (upd_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

endmodule

>>> design/dcpid_checker.sv
module dcpid_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic                          m_tuser,
  input logic [dcpid_pkg::DRIVE_W-1:0] m_tdata
);

  logic [2:0] inflight;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (in_acc && !out_acc) begin
      inflight <= inflight + 3'd1;
    end else if (out_acc && !in_acc) begin
      inflight <= inflight - 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output item changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> inflight != 3'd0)
    else $error("output item without an accepted input");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= 3'd4)
    else $error("more items in flight than pipeline stages");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    inflight == 3'd0 |-> s_tready)
    else $error("empty pipeline refuses input");

endmodule

bind dual_channel_pid_deadzone dcpid_checker u_checker (.*);
